[sv/top_k_truncation_selection_macros.svh]
// Assertion macros for the top-k truncation selection block.
// Used by the port checker; expects clk_i and rst_ni in the enclosing scope.
`ifndef TOP_K_TRUNCATION_SELECTION_MACROS_SVH
`define TOP_K_TRUNCATION_SELECTION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tkts_pkg.sv]
// Shared types and constants for the top-k truncation selection block.
// No dependencies; used by every other file of the block but the macro header.
package tkts_pkg;

  localparam int unsigned ScoreW           = 16;
  localparam int unsigned WinCfgW          = 7;
  localparam int unsigned SlotW            = 6;
  localparam int unsigned MaxPopulationDef = 64;

  localparam logic [WinCfgW-1:0] WinnersReset = WinCfgW'(10);

  // One input transfer
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              last;
  } tkts_in_t;

  // One result transfer
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] source;
    logic             final_res;
  } tkts_out_t;

  // Sequencer commands to the score store and compare unit
  typedef struct packed {
    logic load;   // write an incoming score
    logic seed;   // take the read score as the pass start candidate
    logic cmp;    // compare the read score against the current best
    logic clear;  // zero the score of the current best
  } tkts_ctl_t;

endpackage

[sv/tkts_argmax.sv]
// Score store and shared compare unit of the top-k truncation selection.
// Depends on tkts_pkg; commanded cycle by cycle by the top-level sequencer.
module tkts_argmax #(
  parameter int unsigned MaxPopulation = tkts_pkg::MaxPopulationDef,
  localparam int unsigned IdxW = $clog2(MaxPopulation)
) (
  input  logic                        clk_i,
  input  tkts_pkg::tkts_ctl_t         ctl_i,
  input  logic [IdxW-1:0]             wr_addr_i,
  input  logic [tkts_pkg::ScoreW-1:0] wr_score_i,
  input  logic [IdxW-1:0]             rd_addr_i,
  input  logic [IdxW-1:0]             seed_idx_i,
  input  logic [IdxW-1:0]             cmp_idx_i,
  output logic [IdxW-1:0]             best_idx_o
);

  localparam int unsigned ScoreW = tkts_pkg::ScoreW;

  logic [ScoreW-1:0] mem_q [MaxPopulation];
  logic [ScoreW-1:0] rd_data_q;
  logic [ScoreW-1:0] best_val_q;
  logic [IdxW-1:0]   best_idx_q;

  // Single write port: load a score, or knock out the chosen winner
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mem_q[wr_addr_i] <= wr_score_i;
    end else if (ctl_i.clear) begin
      mem_q[best_idx_q] <= '0;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  // Seed the pass, then replace the best only on a strictly greater score
  always_ff @(posedge clk_i) begin
    if (ctl_i.seed) begin
      best_val_q <= rd_data_q;
      best_idx_q <= seed_idx_i;
    end else if (ctl_i.cmp && (rd_data_q > best_val_q)) begin
      best_val_q <= rd_data_q;
      best_idx_q <= cmp_idx_i;
    end
  end

  assign best_idx_o = best_idx_q;

endmodule

[sv/top_k_truncation_selection.sv]
// Top level of the top-k truncation selection block: sequencer, winner list, result register.
// Depends on tkts_pkg and tkts_argmax.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   input    | in_valid_i / in_stall_o  | in_data_i  (score, last)
//   result   | out_valid_o / out_stall_i| out_data_o (slot, source, final_res)
//   config   | cfg_wr_en_i              | cfg_wr_data_i (winners_count)
//
// A last score starts selection: each winner costs one pass of the shared compare unit
// over the store: seed read, seed, a scan of every loaded score, then the winner is zeroed.
// Each result is then read from the winner list through a register and loaded into the
// output register. Input stalls from the last score until the final result sits in the
// output register. Reset clears the control state and sets winners_count to 10; the
// stores need no clearing.
module top_k_truncation_selection #(
  parameter int unsigned MaxPopulation = tkts_pkg::MaxPopulationDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tkts_pkg::tkts_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tkts_pkg::tkts_out_t          out_data_o,
  input  logic                         cfg_wr_en_i,
  input  logic [tkts_pkg::WinCfgW-1:0] cfg_wr_data_i
);

  localparam int unsigned IdxW    = $clog2(MaxPopulation);
  localparam int unsigned CntW    = $clog2(MaxPopulation + 1);
  localparam int unsigned WinCfgW = tkts_pkg::WinCfgW;
  localparam int unsigned NwW     = (CntW > WinCfgW) ? CntW : WinCfgW;
  localparam int unsigned SlotW   = tkts_pkg::SlotW;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SEED_RD,
    S_SEED,
    S_SCAN,
    S_ZERO,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      nwin_q;
  logic [CntW-1:0]      k_q;
  logic [CntW-1:0]      j_q;
  logic [CntW-1:0]      i_q;
  logic [CntW-1:0]      m_q;
  logic                 out_valid_q;
  tkts_pkg::tkts_out_t  out_q;
  logic [WinCfgW-1:0]   winners_count_q;

  logic [IdxW-1:0]      win_q [MaxPopulation];
  logic [IdxW-1:0]      win_rd_q;

  tkts_pkg::tkts_ctl_t  ctl;
  logic                 in_xfer;
  logic                 cnt_full;
  logic [CntW-1:0]      cnt_inc;
  logic [WinCfgW-1:0]   win_eff;
  logic [CntW-1:0]      nwin_d;
  logic                 scan_end;
  logic                 out_free;
  logic                 out_load;
  logic                 emit_last;
  logic [CntW-1:0]      rd_addr;
  logic [IdxW-1:0]      best_idx;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      winners_count_q <= tkts_pkg::WinnersReset;
    end else if (cfg_wr_en_i) begin
      winners_count_q <= cfg_wr_data_i;
    end
  end

  // Handshake and counter arithmetic
  assign in_stall_o = (state_q != S_LOAD);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cnt_full   = (cnt_q == CntW'(MaxPopulation));
  assign cnt_inc    = cnt_full ? cnt_q : cnt_q + CntW'(1);
  assign scan_end   = (j_q == cnt_q - CntW'(1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_EMIT_LD) && out_free;
  assign emit_last  = (i_q == cnt_q - CntW'(1));

  // Clamp the winner count to one and to the loaded count
  always_comb begin
    win_eff = (winners_count_q == '0) ? WinCfgW'(1) : winners_count_q;
    if (NwW'(win_eff) > NwW'(cnt_inc)) begin
      nwin_d = cnt_inc;
    end else begin
      nwin_d = CntW'(win_eff);
    end
  end

  // Score store read address: start candidate, then a sweep from index zero
  always_comb begin
    case (state_q)
      S_SEED_RD: rd_addr = k_q;
      S_SCAN:    rd_addr = scan_end ? '0 : j_q + CntW'(1);
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    ctl.load  = in_xfer && !cnt_full;
    ctl.seed  = (state_q == S_SEED);
    ctl.cmp   = (state_q == S_SCAN);
    ctl.clear = (state_q == S_ZERO);
  end

  tkts_argmax #(
    .MaxPopulation(MaxPopulation)
  ) u_argmax (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .wr_addr_i  (cnt_q[IdxW-1:0]),
    .wr_score_i (in_data_i.score),
    .rd_addr_i  (rd_addr[IdxW-1:0]),
    .seed_idx_i (k_q[IdxW-1:0]),
    .cmp_idx_i  (j_q[IdxW-1:0]),
    .best_idx_o (best_idx)
  );

  // Winner list: record at the end of each pass, read while emitting
  always_ff @(posedge clk_i) begin
    if (state_q == S_ZERO) begin
      win_q[k_q[IdxW-1:0]] <= best_idx;
    end
    if (state_q == S_EMIT_RD) begin
      win_rd_q <= win_q[m_q[IdxW-1:0]];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      nwin_q      <= '0;
      k_q         <= '0;
      j_q         <= '0;
      i_q         <= '0;
      m_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // drop the result once it is taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            cnt_q <= cnt_inc;
            if (in_data_i.last) begin
              nwin_q  <= nwin_d;
              k_q     <= '0;
              state_q <= S_SEED_RD;
            end
          end
        end
        S_SEED_RD: begin
          state_q <= S_SEED;
        end
        S_SEED: begin
          j_q     <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_end) begin
            state_q <= S_ZERO;
          end else begin
            j_q <= j_q + CntW'(1);
          end
        end
        S_ZERO: begin
          k_q <= k_q + CntW'(1);
          i_q <= '0;
          m_q <= '0;
          if (k_q + CntW'(1) == nwin_q) begin
            state_q <= S_EMIT_RD;
          end else begin
            state_q <= S_SEED_RD;
          end
        end
        S_EMIT_RD: begin
          state_q <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            out_q.slot      <= SlotW'(i_q);
            out_q.source    <= SlotW'(win_rd_q);
            out_q.final_res <= emit_last;
            if (emit_last) begin
              cnt_q   <= '0;
              state_q <= S_LOAD;
            end else begin
              i_q     <= i_q + CntW'(1);
              m_q     <= (m_q + CntW'(1) == nwin_q) ? '0 : m_q + CntW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/tkts_checker.sv]
// Port-level checker for the top-k truncation selection block, with its bind.
// Depends on tkts_pkg and top_k_truncation_selection_macros.svh.
`include "top_k_truncation_selection_macros.svh"

module tkts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input tkts_pkg::tkts_in_t           in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input tkts_pkg::tkts_out_t          out_data_o,
  input logic                         cfg_wr_en_i
);

  logic in_last_xfer;

  assign in_last_xfer = in_valid_i && !in_stall_o && in_data_i.last;

  // a last score hands the block over to selection
  `TKTS_ASSERT_NEXT(a_last_stalls_input, in_last_xfer, in_stall_o, "input open after last score")

  // no new scores while a population is still being emitted
  `TKTS_ASSERT_SAME(a_emit_blocks_input, out_valid_o && !out_data_o.final_res,
    in_stall_o, "input open while results remain")

  // hold a stalled result
  `TKTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")

  // write the winner count only while the block is idle
  `TKTS_ASSERT_SAME(a_cfg_idle, cfg_wr_en_i, !in_stall_o && !out_valid_o, "config write while busy")

endmodule

bind top_k_truncation_selection tkts_checker u_tkts_checker (.*);
